@@ hdl/abbc_pkg.sv @@
// Shared types, constants and the check-word mix for the A/B boot counter advance block.
package abbc_pkg;

    localparam logic [15:0] REC_MAGIC  = 16'hB07E;
    localparam logic [31:0] MIX_SEED   = 32'h0000_6D3A;
    localparam logic [31:0] HALF_RANGE = 32'h8000_0000;

    typedef enum logic {
        SLOT_A = 1'b0,
        SLOT_B = 1'b1
    } t_slot;

    typedef struct packed {
        logic        valid;
        logic [31:0] count;
    } t_lane;

    typedef struct packed {
        logic        a_valid;
        logic        b_valid;
        t_slot       write_slot;
        logic [31:0] next_count;
    } t_merge;

    function automatic logic [15:0] mix16(input logic [31:0] c);
        logic [31:0] m;
        m = c ^ (c >> 16) ^ MIX_SEED;
        m = m ^ (m << 7);
        m = m ^ (m >> 11);
        m = m ^ (m >> 16);
        return m[15:0];
    endfunction

endpackage

@@ hdl/abbc_lane.sv @@
// One slot check lane: magic, nonzero counter and check word, registered.
module abbc_lane
    import abbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_en,
    input  logic [15:0] i_magic,
    input  logic [15:0] i_count_low,
    input  logic [15:0] i_count_high,
    input  logic [15:0] i_check,
    output t_lane       o_lane
);

    logic [31:0] w_count;
    t_lane       n_lane;
    t_lane       r_lane;

    assign w_count = {i_count_high, i_count_low};

    always_comb begin
        n_lane.count = w_count;
        n_lane.valid = (i_magic == REC_MAGIC) && (w_count != 32'd0)
                       && (i_check == mix16(w_count));
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_lane <= n_lane;
        end
    end

    assign o_lane = r_lane;

endmodule

@@ hdl/abbc_merge.sv @@
// Merge stage: pick the newest valid counter (zero if none is valid), advance it and choose the slot to overwrite.
module abbc_merge
    import abbc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_en,
    input  t_lane  i_lane_a,
    input  t_lane  i_lane_b,
    output t_merge o_merge
);

    logic [31:0] w_diff;
    logic        w_b_newer;
    logic [31:0] w_prev;
    logic [31:0] w_inc;
    t_merge      n_merge;
    t_merge      r_merge;

    assign w_diff    = i_lane_b.count - i_lane_a.count;
    assign w_b_newer = (w_diff != 32'd0) && (w_diff < HALF_RANGE);

    always_comb begin
        w_prev             = 32'd0;
        n_merge.write_slot = SLOT_A;
        case ({i_lane_a.valid, i_lane_b.valid})
            2'b11: begin
                if (w_b_newer) begin
                    w_prev             = i_lane_b.count;
                    n_merge.write_slot = SLOT_A;
                end else begin
                    w_prev             = i_lane_a.count;
                    n_merge.write_slot = SLOT_B;
                end
            end
            2'b10: begin
                w_prev             = i_lane_a.count;
                n_merge.write_slot = SLOT_B;
            end
            2'b01: begin
                w_prev             = i_lane_b.count;
                n_merge.write_slot = SLOT_A;
            end
            default: begin
                w_prev             = 32'd0;
                n_merge.write_slot = SLOT_A;
            end
        endcase
        w_inc              = w_prev + 32'd1;
        n_merge.next_count = (w_inc == 32'd0) ? 32'd1 : w_inc;
        n_merge.a_valid    = i_lane_a.valid;
        n_merge.b_valid    = i_lane_b.valid;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_merge <= n_merge;
        end
    end

    assign o_merge = r_merge;

endmodule

@@ hdl/ab_slot_boot_counter_advance_top.sv @@
// Top level of the A/B slot boot counter advance block.
// Pipeline: an accepted word passes the lane, merge and output registers to its result word.
// Throughput: one word per cycle; the three stages advance together unless a
// finished result is stalled at the output register.
// Reset: synchronous, active low; clears the stage valid flags only.
module ab_slot_boot_counter_advance_top
    import abbc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [15:0] i_a_magic,
    input  logic [15:0] i_a_count_low,
    input  logic [15:0] i_a_count_high,
    input  logic [15:0] i_a_check,
    input  logic [15:0] i_b_magic,
    input  logic [15:0] i_b_count_low,
    input  logic [15:0] i_b_count_high,
    input  logic [15:0] i_b_check,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_next_count,
    output logic        o_write_slot,
    output logic [15:0] o_new_magic,
    output logic [15:0] o_new_check,
    output logic        o_a_valid,
    output logic        o_b_valid
);

    logic   w_en;
    logic   r_lane_vld;
    logic   r_merge_vld;
    logic   r_out_vld;
    t_lane  w_lane_a;
    t_lane  w_lane_b;
    t_merge w_merge;
    t_merge r_out;
    logic [15:0] r_check;

    assign w_en    = !(r_out_vld && i_stall);
    assign o_stall = !w_en;

    abbc_lane u_lane_a (
        .i_clk        (i_clk),
        .i_en         (w_en),
        .i_magic      (i_a_magic),
        .i_count_low  (i_a_count_low),
        .i_count_high (i_a_count_high),
        .i_check      (i_a_check),
        .o_lane       (w_lane_a)
    );

    abbc_lane u_lane_b (
        .i_clk        (i_clk),
        .i_en         (w_en),
        .i_magic      (i_b_magic),
        .i_count_low  (i_b_count_low),
        .i_count_high (i_b_count_high),
        .i_check      (i_b_check),
        .o_lane       (w_lane_b)
    );

    abbc_merge u_merge (
        .i_clk    (i_clk),
        .i_en     (w_en),
        .i_lane_a (w_lane_a),
        .i_lane_b (w_lane_b),
        .o_merge  (w_merge)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lane_vld  <= 1'b0;
            r_merge_vld <= 1'b0;
            r_out_vld   <= 1'b0;
        end else if (w_en) begin
            r_lane_vld  <= i_valid;
            r_merge_vld <= r_lane_vld;
            r_out_vld   <= r_merge_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_out   <= w_merge;
            r_check <= mix16(w_merge.next_count);
        end
    end

    assign o_valid      = r_out_vld;
    assign o_next_count = r_out.next_count;
    assign o_write_slot = r_out.write_slot;
    assign o_new_magic  = REC_MAGIC;
    assign o_new_check  = r_check;
    assign o_a_valid    = r_out.a_valid;
    assign o_b_valid    = r_out.b_valid;

endmodule

@@ hdl/abbc_checker.sv @@
// Port-level checker for the A/B slot boot counter advance block, with its bind.
module abbc_checker
    import abbc_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_valid,
    input logic        i_stall,
    input logic [31:0] o_next_count,
    input logic        o_write_slot,
    input logic [15:0] o_new_magic,
    input logic [15:0] o_new_check,
    input logic        o_a_valid,
    input logic        o_b_valid
);

    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_next_count) && $stable(o_new_check))
        else $error("result word changed while stalled");

    a_count_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_next_count != 32'd0 && o_new_magic == REC_MAGIC)
        else $error("bad count or magic");

    a_check_match: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_new_check == mix16(o_next_count))
        else $error("check word does not match count");

    a_none_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !o_a_valid && !o_b_valid |-> o_next_count == 32'd1 && o_write_slot == SLOT_A)
        else $error("empty slots must restart at one in slot A");

    a_single_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && (o_a_valid != o_b_valid) |-> o_write_slot == o_a_valid)
        else $error("single valid slot must be kept");

endmodule

bind ab_slot_boot_counter_advance_top abbc_checker u_abbc_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .o_valid      (o_valid),
    .i_stall      (i_stall),
    .o_next_count (o_next_count),
    .o_write_slot (o_write_slot),
    .o_new_magic  (o_new_magic),
    .o_new_check  (o_new_check),
    .o_a_valid    (o_a_valid),
    .o_b_valid    (o_b_valid)
);
